@@ hdl/pns_pkg.sv @@
// shared types, microcode table and constants for the prime neighbor search unit
package pns_pkg;

    // field widths of the beats and the configuration port, register index and bound reset
    localparam int VALUE_W       = 32;
    localparam int DEFAULT_WIDTH = 32;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;
    localparam int REG_UPPER_BOUND = 0;
    localparam logic [VALUE_W-1:0] BOUND_RESET = 32'd4294967291;

    // command codes
    localparam logic CMD_NEXT = 1'b0;
    localparam logic CMD_PREV = 1'b1;

    // request and response beats
    typedef struct packed {
        logic               command;
        logic [VALUE_W-1:0] value;
    } req_beat_t;

    typedef struct packed {
        logic [VALUE_W-1:0] prime;
        logic               error;
    } rsp_beat_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_INIT,
        OP_STEP,
        OP_D3,
        OP_D5,
        OP_D7,
        OP_DNEXT,
        OP_SQ,
        OP_DIVSTART,
        OP_DIVSTEP,
        OP_EMIT_OK,
        OP_EMIT_ERR
    } op_t;

    // jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_ARG_BAD,
        C_END,
        C_ONE,
        C_SMALL,
        C_DIV_MORE,
        C_REM_ZERO,
        C_SQ_GT,
        C_OUT_BUSY
    } cond_t;

    localparam int UADDR_W = 5;

    typedef struct packed {
        op_t                op;
        cond_t              cond;
        logic [UADDR_W-1:0] target;
    } uword_t;

    // status flags from datapath to sequencer
    typedef struct packed {
        logic arg_bad;
        logic at_end;
        logic is_one;
        logic small_prime;
        logic div_more;
        logic rem_zero;
        logic sq_gt;
        logic out_busy;
    } status_t;

    // program labels
    localparam logic [UADDR_W-1:0] A_IDLE   = 5'd0;
    localparam logic [UADDR_W-1:0] A_CHECK  = 5'd1;
    localparam logic [UADDR_W-1:0] A_INIT   = 5'd2;
    localparam logic [UADDR_W-1:0] A_TEST   = 5'd3;
    localparam logic [UADDR_W-1:0] A_ONE    = 5'd4;
    localparam logic [UADDR_W-1:0] A_SMALL  = 5'd5;
    localparam logic [UADDR_W-1:0] A_LD3    = 5'd6;
    localparam logic [UADDR_W-1:0] A_DS3    = 5'd7;
    localparam logic [UADDR_W-1:0] A_DV3    = 5'd8;
    localparam logic [UADDR_W-1:0] A_RZ3    = 5'd9;
    localparam logic [UADDR_W-1:0] A_LD5    = 5'd10;
    localparam logic [UADDR_W-1:0] A_DS5    = 5'd11;
    localparam logic [UADDR_W-1:0] A_DV5    = 5'd12;
    localparam logic [UADDR_W-1:0] A_RZ5    = 5'd13;
    localparam logic [UADDR_W-1:0] A_LD7    = 5'd14;
    localparam logic [UADDR_W-1:0] A_WLOOP  = 5'd15;
    localparam logic [UADDR_W-1:0] A_SQCMP  = 5'd16;
    localparam logic [UADDR_W-1:0] A_DSW    = 5'd17;
    localparam logic [UADDR_W-1:0] A_DVW    = 5'd18;
    localparam logic [UADDR_W-1:0] A_RZW    = 5'd19;
    localparam logic [UADDR_W-1:0] A_WNEXT  = 5'd20;
    localparam logic [UADDR_W-1:0] A_ADV    = 5'd21;
    localparam logic [UADDR_W-1:0] A_OK     = 5'd22;
    localparam logic [UADDR_W-1:0] A_OKDONE = 5'd23;
    localparam logic [UADDR_W-1:0] A_ERR    = 5'd24;
    localparam logic [UADDR_W-1:0] A_ERDONE = 5'd25;

    function automatic uword_t uw(op_t op, cond_t cond, logic [UADDR_W-1:0] target);
        uword_t w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // control store: jump to target when the condition holds, else fall through
    function automatic uword_t ucode_word(logic [UADDR_W-1:0] addr);
        uword_t w;
        unique case (addr)
            A_IDLE:   w = uw(OP_LOAD,     C_NO_IN,    A_IDLE);
            A_CHECK:  w = uw(OP_NOP,      C_ARG_BAD,  A_ERR);
            A_INIT:   w = uw(OP_INIT,     C_NEVER,    A_IDLE);
            A_TEST:   w = uw(OP_NOP,      C_END,      A_ERR);
            A_ONE:    w = uw(OP_NOP,      C_ONE,      A_ADV);
            A_SMALL:  w = uw(OP_NOP,      C_SMALL,    A_OK);
            A_LD3:    w = uw(OP_D3,       C_NEVER,    A_IDLE);
            A_DS3:    w = uw(OP_DIVSTART, C_NEVER,    A_IDLE);
            A_DV3:    w = uw(OP_DIVSTEP,  C_DIV_MORE, A_DV3);
            A_RZ3:    w = uw(OP_NOP,      C_REM_ZERO, A_ADV);
            A_LD5:    w = uw(OP_D5,       C_NEVER,    A_IDLE);
            A_DS5:    w = uw(OP_DIVSTART, C_NEVER,    A_IDLE);
            A_DV5:    w = uw(OP_DIVSTEP,  C_DIV_MORE, A_DV5);
            A_RZ5:    w = uw(OP_NOP,      C_REM_ZERO, A_ADV);
            A_LD7:    w = uw(OP_D7,       C_NEVER,    A_IDLE);
            A_WLOOP:  w = uw(OP_SQ,       C_NEVER,    A_IDLE);
            A_SQCMP:  w = uw(OP_NOP,      C_SQ_GT,    A_OK);
            A_DSW:    w = uw(OP_DIVSTART, C_NEVER,    A_IDLE);
            A_DVW:    w = uw(OP_DIVSTEP,  C_DIV_MORE, A_DVW);
            A_RZW:    w = uw(OP_NOP,      C_REM_ZERO, A_ADV);
            A_WNEXT:  w = uw(OP_DNEXT,    C_ALWAYS,   A_WLOOP);
            A_ADV:    w = uw(OP_STEP,     C_ALWAYS,   A_TEST);
            A_OK:     w = uw(OP_EMIT_OK,  C_OUT_BUSY, A_OK);
            A_OKDONE: w = uw(OP_NOP,      C_ALWAYS,   A_IDLE);
            A_ERR:    w = uw(OP_EMIT_ERR, C_OUT_BUSY, A_ERR);
            A_ERDONE: w = uw(OP_NOP,      C_ALWAYS,   A_IDLE);
            default:  w = uw(OP_NOP,      C_ALWAYS,   A_IDLE);
        endcase
        return w;
    endfunction

    // mod-30 wheel gaps starting from divisor 7
    function automatic logic [2:0] wheel_step(logic [2:0] k);
        logic [2:0] s;
        unique case (k)
            3'd0:    s = 3'd4;
            3'd1:    s = 3'd2;
            3'd2:    s = 3'd4;
            3'd3:    s = 3'd2;
            3'd4:    s = 3'd4;
            3'd5:    s = 3'd6;
            3'd6:    s = 3'd2;
            3'd7:    s = 3'd6;
            default: s = 3'd6;
        endcase
        return s;
    endfunction

endpackage

@@ hdl/pns_sequencer.sv @@
// microprogram sequencer: step counter, control store and conditional jumps
module pns_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  pns_pkg::status_t  status,
    output logic              idle,
    output pns_pkg::op_t      op
);

    logic [pns_pkg::UADDR_W-1:0] upc_reg;
    logic [pns_pkg::UADDR_W-1:0] upc_next;
    pns_pkg::uword_t             word;
    logic                        take;
    logic                        accept;

    assign word   = pns_pkg::ucode_word(upc_reg);
    assign idle   = (upc_reg == pns_pkg::A_IDLE);
    assign accept = idle & req_valid;

    // condition select
    always_comb
    begin
        unique case (word.cond)
            pns_pkg::C_NEVER:    take = 1'b0;
            pns_pkg::C_ALWAYS:   take = 1'b1;
            pns_pkg::C_NO_IN:    take = !accept;
            pns_pkg::C_ARG_BAD:  take = status.arg_bad;
            pns_pkg::C_END:      take = status.at_end;
            pns_pkg::C_ONE:      take = status.is_one;
            pns_pkg::C_SMALL:    take = status.small_prime;
            pns_pkg::C_DIV_MORE: take = status.div_more;
            pns_pkg::C_REM_ZERO: take = status.rem_zero;
            pns_pkg::C_SQ_GT:    take = status.sq_gt;
            pns_pkg::C_OUT_BUSY: take = status.out_busy;
            default:             take = 1'b0;
        endcase
    end

    // next step
    always_comb
    begin
        if (take)
        begin
            upc_next = word.target;
        end
        else
        begin
            upc_next = upc_reg + pns_pkg::UADDR_W'(1);
        end
    end

    // operation issued to the datapath, gated by handshakes
    always_comb
    begin
        op = word.op;
        if ((word.op == pns_pkg::OP_LOAD) && !accept)
        begin
            op = pns_pkg::OP_NOP;
        end
        if (((word.op == pns_pkg::OP_EMIT_OK) || (word.op == pns_pkg::OP_EMIT_ERR))
            && status.out_busy)
        begin
            op = pns_pkg::OP_NOP;
        end
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= pns_pkg::A_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

@@ hdl/pns_datapath.sv @@
// candidate, divisor, shared remainder unit and response register
module pns_datapath #(
    parameter int WIDTH = pns_pkg::DEFAULT_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pns_pkg::op_t                 op,
    input  pns_pkg::req_beat_t           req,
    input  logic [pns_pkg::VALUE_W-1:0]  upper_bound,
    input  logic                         rsp_stall,
    output pns_pkg::status_t             status,
    output logic                         rsp_valid,
    output pns_pkg::rsp_beat_t           rsp
);

    // arithmetic width, candidate width with headroom, divisor width
    localparam int AW    = (WIDTH < pns_pkg::VALUE_W) ? WIDTH : pns_pkg::VALUE_W;
    localparam int CW    = AW + 1;
    localparam int DW    = (CW + 1) / 2 + 1;
    localparam int CNT_W = $clog2(CW);

    logic                 cmd_reg,  cmd_next;
    logic [AW-1:0]        n_reg,    n_next;
    logic [CW-1:0]        p_reg,    p_next;
    logic [DW-1:0]        d_reg,    d_next;
    logic [2:0]           k_reg,    k_next;
    logic [2*DW-1:0]      dsq_reg,  dsq_next;
    logic [CW-1:0]        q_reg,    q_next;
    logic [DW-1:0]        r_reg,    r_next;
    logic [CNT_W-1:0]     cnt_reg,  cnt_next;
    logic                 vld_reg,  vld_next;
    pns_pkg::rsp_beat_t   rsp_reg,  rsp_next;

    logic [AW-1:0]        bound;
    logic [DW:0]          r_trial;
    logic                 out_free;

    assign bound    = upper_bound[AW-1:0];
    assign out_free = !vld_reg || !rsp_stall;
    assign r_trial  = {r_reg, q_reg[CW-1]};

    // status flags for the jump conditions
    always_comb
    begin
        status.arg_bad     = (cmd_reg == pns_pkg::CMD_NEXT) ? (n_reg >= bound)
                                                            : (n_reg <= AW'(3));
        status.at_end      = (cmd_reg == pns_pkg::CMD_NEXT) ? (p_reg > {1'b0, bound})
                                                            : (p_reg <= CW'(2));
        status.is_one      = (p_reg == CW'(1));
        status.small_prime = (p_reg == CW'(3)) || (p_reg == CW'(5));
        status.div_more    = (cnt_reg != '0);
        status.rem_zero    = (r_reg == '0);
        status.sq_gt       = (dsq_reg > (2*DW)'(p_reg));
        status.out_busy    = !out_free;
    end

    // datapath operations
    always_comb
    begin
        cmd_next = cmd_reg;
        n_next   = n_reg;
        p_next   = p_reg;
        d_next   = d_reg;
        k_next   = k_reg;
        dsq_next = dsq_reg;
        q_next   = q_reg;
        r_next   = r_reg;
        cnt_next = cnt_reg;
        rsp_next = rsp_reg;
        vld_next = vld_reg && rsp_stall;
        unique case (op)
            pns_pkg::OP_NOP:
            begin
            end
            pns_pkg::OP_LOAD:
            begin
                cmd_next = req.command;
                n_next   = req.value[AW-1:0];
            end
            pns_pkg::OP_INIT:
            begin
                if (cmd_reg == pns_pkg::CMD_NEXT)
                begin
                    p_next = {1'b0, n_reg} + (n_reg[0] ? CW'(2) : CW'(1));
                end
                else
                begin
                    p_next = {1'b0, n_reg} - (n_reg[0] ? CW'(2) : CW'(1));
                end
            end
            pns_pkg::OP_STEP:
            begin
                if (cmd_reg == pns_pkg::CMD_NEXT)
                begin
                    p_next = p_reg + CW'(2);
                end
                else
                begin
                    p_next = p_reg - CW'(2);
                end
            end
            pns_pkg::OP_D3:
            begin
                d_next = DW'(3);
            end
            pns_pkg::OP_D5:
            begin
                d_next = DW'(5);
            end
            pns_pkg::OP_D7:
            begin
                d_next = DW'(7);
                k_next = 3'd0;
            end
            pns_pkg::OP_DNEXT:
            begin
                d_next = d_reg + DW'(pns_pkg::wheel_step(k_reg));
                k_next = k_reg + 3'd1;
            end
            pns_pkg::OP_SQ:
            begin
                dsq_next = d_reg * d_reg;
            end
            pns_pkg::OP_DIVSTART:
            begin
                q_next   = p_reg;
                r_next   = '0;
                cnt_next = CNT_W'(CW - 1);
            end
            pns_pkg::OP_DIVSTEP:
            begin
                // one restoring remainder bit per cycle
                if (r_trial >= {1'b0, d_reg})
                begin
                    r_next = DW'(r_trial - {1'b0, d_reg});
                end
                else
                begin
                    r_next = r_trial[DW-1:0];
                end
                q_next   = {q_reg[CW-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
            end
            pns_pkg::OP_EMIT_OK:
            begin
                rsp_next.prime = pns_pkg::VALUE_W'(p_reg[AW-1:0]);
                rsp_next.error = 1'b0;
                vld_next       = 1'b1;
            end
            pns_pkg::OP_EMIT_ERR:
            begin
                rsp_next.prime = '0;
                rsp_next.error = 1'b1;
                vld_next       = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // working registers
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        n_reg   <= n_next;
        p_reg   <= p_next;
        d_reg   <= d_next;
        k_reg   <= k_next;
        dsq_reg <= dsq_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        cnt_reg <= cnt_next;
        rsp_reg <= rsp_next;
    end

    // response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign rsp_valid = vld_reg;
    assign rsp       = rsp_reg;

endmodule

@@ hdl/prime_neighbor_search_unit.sv @@
// top level of the prime neighbor search unit: register port, sequencer, datapath
//
//  channel  | signals                          | beat
//  ---------+----------------------------------+---------------------------
//  request  | req_valid, req_stall, req        | command, value
//  response | rsp_valid, rsp_stall, rsp        | prime, error
//  config   | psel penable pwrite paddr pwdata | upper_bound at byte 0
//
// each trial divide runs in the shared restoring unit, one remainder bit per cycle,
// over CW = min(WIDTH,32)+1 bits; a candidate is divided by the wheel divisors up to
// its square root. reset idles the sequencer, drops the response and restores
// upper_bound to 4294967291; there is no clearing pass. req_stall is high while a
// search runs; a response held by rsp_stall blocks only the final write of the next
// result.
module prime_neighbor_search_unit #(
    parameter int WIDTH = pns_pkg::DEFAULT_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  pns_pkg::req_beat_t            req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output pns_pkg::rsp_beat_t            rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pns_pkg::PADDR_W-1:0]   paddr,
    input  logic [pns_pkg::PDATA_W-1:0]   pwdata,
    output logic [pns_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [pns_pkg::VALUE_W-1:0] bound_reg;
    logic [pns_pkg::VALUE_W-1:0] bound_next;
    logic                        reg_sel;
    logic                        idle;
    pns_pkg::op_t                op;
    pns_pkg::status_t            status;

    // register decode
    assign pready  = 1'b1;
    assign reg_sel = (paddr[pns_pkg::PADDR_W-1:2] == pns_pkg::REG_UPPER_BOUND[0:0]);

    always_comb
    begin
        bound_next = bound_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            bound_next = pwdata;
        end
    end

    always_comb
    begin
        prdata = reg_sel ? bound_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg <= pns_pkg::BOUND_RESET;
        end
        else
        begin
            bound_reg <= bound_next;
        end
    end

    assign req_stall = !idle;

    // control store and step counter
    pns_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .status    (status),
        .idle      (idle),
        .op        (op)
    );

    // arithmetic and response register
    pns_datapath #(
        .WIDTH (WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .req         (req),
        .upper_bound (bound_reg),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .rsp_valid   (rsp_valid),
        .rsp         (rsp)
    );

endmodule

@@ sim/prime_neighbor_search_unit_test.sv @@
// self-checking testbench for the prime neighbor search unit
module prime_neighbor_search_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pns_pkg::*;

    localparam logic [PADDR_W-1:0] LIMIT_ADDR  = PADDR_W'(4 * REG_UPPER_BOUND);
    localparam int unsigned        CYCLE_LIMIT = 6000000;
    localparam int unsigned        SETTLE      = 64;
    localparam int unsigned        PHASES      = 6;
    localparam int unsigned        PHASE_ITEMS = 17;
    localparam logic               TYPED       = 1'b1;
    localparam logic               PREDICT     = 1'b0;
    localparam logic               OK          = 1'b0;
    localparam logic               FAIL        = 1'b1;
    localparam logic [31:0]        TOP         = 32'hFFFF_FFFF;

    // one directed beat: command, start value, bound in force, optional known result
    typedef struct packed {
        logic        command;
        logic [31:0] value;
        logic [31:0] limit;
        logic        typed;
        logic [31:0] prime;
        logic        error;
    } probe_t;

    localparam int PROBE_COUNT = 25;
    localparam probe_t PROBES [PROBE_COUNT] = '{
        '{CMD_NEXT, 32'd0,          BOUND_RESET, TYPED,   32'd3,   OK},
        '{CMD_NEXT, 32'd1,          BOUND_RESET, TYPED,   32'd3,   OK},
        '{CMD_NEXT, 32'd2,          BOUND_RESET, TYPED,   32'd3,   OK},
        '{CMD_NEXT, 32'd3,          BOUND_RESET, TYPED,   32'd5,   OK},
        '{CMD_NEXT, 32'd24,         BOUND_RESET, TYPED,   32'd29,  OK},
        '{CMD_NEXT, 32'd113,        BOUND_RESET, PREDICT, 32'd0,   OK},
        '{CMD_NEXT, 32'd1000,       BOUND_RESET, PREDICT, 32'd0,   OK},
        '{CMD_PREV, 32'd0,          BOUND_RESET, TYPED,   32'd0,   FAIL},
        '{CMD_PREV, 32'd1,          BOUND_RESET, TYPED,   32'd0,   FAIL},
        '{CMD_PREV, 32'd2,          BOUND_RESET, TYPED,   32'd0,   FAIL},
        '{CMD_PREV, 32'd3,          BOUND_RESET, TYPED,   32'd0,   FAIL},
        '{CMD_PREV, 32'd4,          BOUND_RESET, TYPED,   32'd3,   OK},
        '{CMD_PREV, 32'd5,          BOUND_RESET, TYPED,   32'd3,   OK},
        '{CMD_PREV, 32'd6,          BOUND_RESET, TYPED,   32'd5,   OK},
        '{CMD_PREV, 32'd9,          BOUND_RESET, TYPED,   32'd7,   OK},
        '{CMD_PREV, 32'd1000,       BOUND_RESET, TYPED,   32'd997, OK},
        '{CMD_NEXT, 32'd4294967291, BOUND_RESET, TYPED,   32'd0,   FAIL},
        '{CMD_NEXT, 32'd4294967292, BOUND_RESET, TYPED,   32'd0,   FAIL},
        '{CMD_NEXT, 32'd0,          32'd3,       TYPED,   32'd3,   OK},
        '{CMD_NEXT, 32'd2,          32'd3,       TYPED,   32'd3,   OK},
        '{CMD_NEXT, 32'd3,          32'd3,       TYPED,   32'd0,   FAIL},
        '{CMD_NEXT, 32'd6,          32'd10,      TYPED,   32'd7,   OK},
        '{CMD_NEXT, 32'd7,          32'd10,      TYPED,   32'd0,   FAIL},
        '{CMD_NEXT, 32'd4294967294, TOP,         TYPED,   32'd0,   FAIL},
        '{CMD_NEXT, TOP,            TOP,         TYPED,   32'd0,   FAIL}
    };

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    req_beat_t            req       = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_beat_t            rsp;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [PADDR_W-1:0]   paddr     = '0;
    logic [PDATA_W-1:0]   pwdata    = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    rsp_beat_t            awaited_primes [$];
    rsp_beat_t            oldest_prime;
    logic [31:0]          search_limit   = BOUND_RESET;
    int unsigned          mismatch_count = 0;
    int unsigned          cycle_count    = 0;
    int unsigned          stall_left     = 0;
    int unsigned          stall_roll;

    prime_neighbor_search_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // trial division by 2, 3, 5 and then the mod-30 wheel from 7
    function automatic bit trial_prime(longint unsigned v);
        int unsigned     gaps [8] = '{4, 2, 4, 2, 4, 6, 2, 6};
        longint unsigned d;
        int unsigned     k;
        if (v < 2)
            return 1'b0;
        if (v == 2 || v == 3 || v == 5)
            return 1'b1;
        if (v % 2 == 0 || v % 3 == 0 || v % 5 == 0)
            return 1'b0;
        d = 7;
        k = 0;
        while (d * d <= v)
        begin
            if (v % d == 0)
                return 1'b0;
            d = d + gaps[k];
            k = (k + 1) % 8;
        end
        return 1'b1;
    endfunction

    // odd prime neighbor of n; candidates are 64 bits so the upward walk never wraps
    function automatic rsp_beat_t neighbor_prime(logic command, logic [31:0] n,
                                                 logic [31:0] limit);
        rsp_beat_t       found;
        longint unsigned p;
        logic            fail;
        fail = 1'b0;
        p    = 0;
        if (command == CMD_NEXT)
        begin
            if (n >= limit)
                fail = 1'b1;
            else
            begin
                p = {32'd0, n} + (n[0] ? 64'd2 : 64'd1);
                while (p <= {32'd0, limit} && !trial_prime(p))
                    p = p + 2;
                if (p > {32'd0, limit})
                    fail = 1'b1;
            end
        end
        else
        begin
            if (n <= 32'd3)
                fail = 1'b1;
            else
            begin
                p = {32'd0, n} - (n[0] ? 64'd2 : 64'd1);
                while (p > 2 && !trial_prime(p))
                    p = p - 2;
                if (p <= 2)
                    fail = 1'b1;
            end
        end
        found.prime = fail ? 32'd0 : p[31:0];
        found.error = fail;
        return found;
    endfunction

    // sender gap: mostly none or short, now and then long
    function automatic int unsigned idle_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // present one request beat and log its expected result once it is taken
    task automatic send_request(logic command, logic [31:0] value, logic typed,
                                rsp_beat_t known);
        req_beat_t beat;
        beat.command = command;
        beat.value   = value;
        req       <= beat;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        awaited_primes.push_back(typed ? known : neighbor_prime(command, value, search_limit));
    endtask

    task automatic sender_gap();
        int unsigned pause;
        pause = idle_gap();
        if (pause != 0)
        begin
            req_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
    endtask

    // wait until every expected result has come back
    task automatic drain();
        do
            @(posedge clk);
        while (awaited_primes.size() != 0);
    endtask

    // write upper_bound, then read it back in the same select
    task automatic program_limit(logic [31:0] limit);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= limit;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== limit)
        begin
            $error("upper_bound: expected %0d, got %0d", limit, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        search_limit = limit;
    endtask

    // receiver stall: short bursts, some long holds, some long free stretches
    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else
        begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 35)
            begin
                rsp_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end
            else if (stall_roll < 40)
            begin
                rsp_stall  <= 1'b1;
                stall_left <= $urandom_range(20, 60);
            end
            else if (stall_roll < 45)
            begin
                rsp_stall  <= 1'b0;
                stall_left <= $urandom_range(100, 300);
            end
            else
            begin
                rsp_stall  <= 1'b0;
                stall_left <= $urandom_range(0, 3);
            end
        end
    end

    // result beat check against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (awaited_primes.size() == 0)
            begin
                $error("unexpected result beat: prime %0d, error %0b", rsp.prime, rsp.error);
                mismatch_count++;
            end
            else
            begin
                oldest_prime = awaited_primes.pop_front();
                if (rsp.prime !== oldest_prime.prime)
                begin
                    $error("prime: expected %0d, got %0d", oldest_prime.prime, rsp.prime);
                    mismatch_count++;
                end
                if (rsp.error !== oldest_prime.error)
                begin
                    $error("error: expected %0b, got %0b", oldest_prime.error, rsp.error);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("prime_neighbor_search_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        logic        command;
        logic [31:0] value;
        logic [31:0] limit;
        int unsigned roll;
        logic [31:0] phase_limits [PHASES];

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed beats, reprogramming the bound when a row asks for another one
        for (int i = 0; i < PROBE_COUNT; i++)
        begin
            if (PROBES[i].limit != search_limit)
            begin
                req_valid <= 1'b0;
                drain();
                program_limit(PROBES[i].limit);
            end
            send_request(PROBES[i].command, PROBES[i].value, PROBES[i].typed,
                         {PROBES[i].prime, PROBES[i].error});
            sender_gap();
        end

        phase_limits[0] = $urandom_range(3, 3000);
        phase_limits[1] = TOP;
        phase_limits[2] = 32'd3;
        phase_limits[3] = BOUND_RESET;
        phase_limits[4] = $urandom_range(32'h0001_0000, 32'h0010_0000);
        phase_limits[5] = $urandom;

        // random beats; values stay small where a search would be long
        for (int ph = 0; ph < PHASES; ph++)
        begin
            req_valid <= 1'b0;
            drain();
            program_limit(phase_limits[ph]);
            limit = phase_limits[ph];
            for (int j = 0; j < PHASE_ITEMS; j++)
            begin
                roll    = $urandom_range(0, 99);
                command = 1'($urandom_range(0, 1));
                if (roll < 10)
                    value = $urandom_range(0, 8);
                else if (roll < 45)
                    value = $urandom_range(0, 4095);
                else if (roll < 70)
                    value = $urandom_range(0, 65535);
                else if (roll < 75)
                    value = $urandom_range(0, 32'h0010_0000);
                else if (roll < 85)
                begin
                    // around the bound, cheap only when the bound is small
                    if (limit <= 32'h0010_0000)
                        value = (limit > 16) ? limit - 16 + $urandom_range(0, 32)
                                             : $urandom_range(0, 32);
                    else
                    begin
                        command = CMD_NEXT;
                        value   = limit + $urandom_range(0, ~limit);
                    end
                end
                else
                begin
                    // wide values only where the bound rejects them at once
                    value = $urandom;
                    if (value >= limit)
                        command = CMD_NEXT;
                    else
                        value = value & 32'h0000_0FFF;
                end
                send_request(command, value, PREDICT, '0);
                sender_gap();
                if ($urandom_range(0, 7) == 0)
                begin
                    req_valid <= 1'b0;
                    drain();
                end
            end
        end

        req_valid <= 1'b0;
        drain();
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("prime_neighbor_search_unit verification clean");
        else
            $display("prime_neighbor_search_unit verification failed");
        $finish;
    end

endmodule

@@ files.f @@
hdl/pns_pkg.sv
hdl/pns_sequencer.sv
hdl/pns_datapath.sv
hdl/prime_neighbor_search_unit.sv
sim/prime_neighbor_search_unit_test.sv
